// ===== rtl/sbte_pkg.sv =====
// Shared constants, types and digit tables for the balanced ternary stitch encoder.
`default_nettype none

package sbte_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int DELTA_W         = 8;
	localparam int NUM_DIGITS      = 5;
	localparam int DELTA_LIMIT     = 121;

	localparam logic [7:0] SYNC_BITS      = 8'h03;
	localparam logic [7:0] END_BYTE2      = 8'hF3;
	localparam logic [7:0] JUMP_TRIM_BITS = 8'h83;
	localparam logic [7:0] STOP_BITS      = 8'hC3;

	// digit slots, most significant first
	localparam int D81 = 0;
	localparam int D27 = 1;
	localparam int D9  = 2;
	localparam int D3  = 3;
	localparam int D1  = 4;

	typedef logic signed [DELTA_W-1:0] delta_t;

	localparam delta_t DIGIT_WEIGHT [NUM_DIGITS] = '{8'sd81, 8'sd27, 8'sd9, 8'sd3, 8'sd1};
	localparam delta_t DIGIT_THRESH [NUM_DIGITS] = '{8'sd41, 8'sd14, 8'sd5, 8'sd2, 8'sd1};

	typedef struct packed {
		logic [NUM_DIGITS-1:0] pos;
		logic [NUM_DIGITS-1:0] neg;
	} digits_t;

endpackage

`default_nettype wire

// ===== rtl/sbte_stitch_if.sv =====
// Stitch input channel: absolute position and control marks.
`default_nettype none

interface sbte_stitch_if #(
	parameter int COORD_WIDTH = sbte_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic                          end_mark;
	logic                          jump_mark;
	logic                          trim_mark;
	logic                          stop_mark;

	modport source (
		output valid, pos_x, pos_y, end_mark, jump_mark, trim_mark, stop_mark,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, end_mark, jump_mark, trim_mark, stop_mark,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/sbte_record_if.sv =====
// Record output channel: three encoded bytes and the range flag.
`default_nettype none

interface sbte_record_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic       range_error;

	modport source (
		output valid, out_byte0, out_byte1, out_byte2, range_error,
		input  ready
	);
	modport sink (
		input  valid, out_byte0, out_byte1, out_byte2, range_error,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/sbte_digits.sv =====
// Balanced ternary digit extraction for one clamped axis delta.
`default_nettype none

module sbte_digits (
	input  sbte_pkg::delta_t  delta,
	output sbte_pkg::digits_t digits
);
	import sbte_pkg::*;

	delta_t rem;

	// greedy peel from 81 down to 1; the remainder always stays within +-121
	always_comb begin
		rem    = delta;
		digits = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (rem >= DIGIT_THRESH[i]) begin
				digits.pos[i] = 1'b1;
				rem = rem - DIGIT_WEIGHT[i];
			end else if (rem <= -DIGIT_THRESH[i]) begin
				digits.neg[i] = 1'b1;
				rem = rem + DIGIT_WEIGHT[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stitch_balanced_ternary_encoder.sv =====
// Stitch encoder top level: delta, clamp, ternary digits and three-byte record.
//
// Usage: absolute stitch positions (0.1 mm units) arrive on the stitch channel
// with end, jump, trim and stop marks; one three-byte record per stitch leaves
// on the rec channel, together with a flag set when either axis delta lay
// outside +-121 and was clamped. Both channels transfer on valid and ready high.
// Throughput is one stitch per cycle unless rec stalls: stage one holds the
// delta taken against the last position register and clamps it, stage two
// holds the finished bytes, and its valid drives the record's valid.
// The last position advances on every input transfer, including end records.
// When the receiver stalls, each stage holds its item; the input keeps taking
// stitches until both stages are full, then ready drops.
// Reset clears both stage valid flags and sets the last position to zero.
`default_nettype none

module stitch_balanced_ternary_encoder #(
	parameter int COORD_WIDTH = sbte_pkg::COORD_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sbte_stitch_if.sink   stitch,
	sbte_record_if.source rec
);
	import sbte_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam logic signed [DW-1:0] LIM_P = DW'(DELTA_LIMIT);
	localparam logic signed [DW-1:0] LIM_N = -LIM_P;

	logic signed [COORD_WIDTH-1:0] last_x_q;
	logic signed [COORD_WIDTH-1:0] last_y_q;

	logic signed [DW-1:0] diff_x;
	logic signed [DW-1:0] diff_y;
	delta_t               clamp_x;
	delta_t               clamp_y;
	logic                 err_x;
	logic                 err_y;

	logic   v_s1;
	delta_t dx_s1;
	delta_t dy_s1;
	logic   err_s1;
	logic   end_s1;
	logic   jt_s1;
	logic   stop_s1;

	logic       v_s2;
	logic [7:0] byte0_s2;
	logic [7:0] byte1_s2;
	logic [7:0] byte2_s2;
	logic       err_s2;

	logic ready_s2;
	logic ready_s1;
	logic take_in;

	digits_t dig_x;
	digits_t dig_y;
	logic [7:0] byte0;
	logic [7:0] byte1;
	logic [7:0] byte2;

	assign ready_s2     = !v_s2 || rec.ready;
	assign ready_s1     = !v_s1 || ready_s2;
	assign stitch.ready = ready_s1;
	assign take_in      = stitch.valid && ready_s1;

	// exact delta, one extra bit so it cannot wrap
	assign diff_x = DW'(stitch.pos_x) - DW'(last_x_q);
	assign diff_y = DW'(stitch.pos_y) - DW'(last_y_q);

	always_comb begin
		err_x = 1'b0;
		if (diff_x > LIM_P) begin
			clamp_x = delta_t'(DELTA_LIMIT);
			err_x   = 1'b1;
		end else if (diff_x < LIM_N) begin
			clamp_x = -delta_t'(DELTA_LIMIT);
			err_x   = 1'b1;
		end else begin
			clamp_x = diff_x[DELTA_W-1:0];
		end
	end

	always_comb begin
		err_y = 1'b0;
		if (diff_y > LIM_P) begin
			clamp_y = delta_t'(DELTA_LIMIT);
			err_y   = 1'b1;
		end else if (diff_y < LIM_N) begin
			clamp_y = -delta_t'(DELTA_LIMIT);
			err_y   = 1'b1;
		end else begin
			clamp_y = diff_y[DELTA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (take_in) begin
			last_x_q <= stitch.pos_x;
			last_y_q <= stitch.pos_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= stitch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			dx_s1   <= clamp_x;
			dy_s1   <= clamp_y;
			err_s1  <= err_x || err_y;
			end_s1  <= stitch.end_mark;
			jt_s1   <= stitch.jump_mark || stitch.trim_mark;
			stop_s1 <= stitch.stop_mark;
		end
	end

	sbte_digits u_digits_x (
		.delta  (dx_s1),
		.digits (dig_x)
	);

	sbte_digits u_digits_y (
		.delta  (dy_s1),
		.digits (dig_y)
	);

	// place digit pairs; end replaces the record, marks OR into byte 2 afterwards
	always_comb begin
		byte0 = {dig_y.pos[D1], dig_y.neg[D1], dig_y.pos[D9], dig_y.neg[D9],
			dig_x.neg[D9], dig_x.pos[D9], dig_x.neg[D1], dig_x.pos[D1]};
		byte1 = {dig_y.pos[D3], dig_y.neg[D3], dig_y.pos[D27], dig_y.neg[D27],
			dig_x.neg[D27], dig_x.pos[D27], dig_x.neg[D3], dig_x.pos[D3]};
		byte2 = {2'b00, dig_y.pos[D81], dig_y.neg[D81],
			dig_x.neg[D81], dig_x.pos[D81], 2'b00} | SYNC_BITS;
		if (end_s1) begin
			byte0 = '0;
			byte1 = '0;
			byte2 = END_BYTE2;
		end
		if (jt_s1) begin
			byte2 = byte2 | JUMP_TRIM_BITS;
		end
		if (stop_s1) begin
			byte2 = byte2 | STOP_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			byte0_s2 <= byte0;
			byte1_s2 <= byte1;
			byte2_s2 <= byte2;
			err_s2   <= err_s1;
		end
	end

	assign rec.valid       = v_s2;
	assign rec.out_byte0   = byte0_s2;
	assign rec.out_byte1   = byte1_s2;
	assign rec.out_byte2   = byte2_s2;
	assign rec.range_error = err_s2;

`ifndef ASSERT_OFF
	a_last_pos_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> (last_x_q == $past(stitch.pos_x)) && (last_y_q == $past(stitch.pos_y)))
		else $error("last position not updated from accepted stitch");

	a_delta_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (dx_s1 <= delta_t'(DELTA_LIMIT)) && (dx_s1 >= -delta_t'(DELTA_LIMIT))
			&& (dy_s1 <= delta_t'(DELTA_LIMIT)) && (dy_s1 >= -delta_t'(DELTA_LIMIT)))
		else $error("stage one delta outside clamp range");

	a_digit_sign_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ((dig_x.pos & dig_x.neg) == '0) && ((dig_y.pos & dig_y.neg) == '0))
		else $error("digit has both signs set");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ready_s2) |=> v_s2)
		else $error("stage one item lost on advance");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the balanced ternary stitch record encoder.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sbte_pkg::*;

	localparam int CW         = COORD_WIDTH_DEF;
	localparam int HALF_CLK   = 6;
	localparam int RESET_CYC  = 4;
	localparam int HOLD_CYC   = 60;
	localparam int HOLD_ITEMS = 30;
	localparam int RAND_ITEMS = 1120;
	localparam int QUIET_FROM = 950;
	localparam int TAIL_CYC   = 8;
	localparam int CYCLE_CAP  = 200000;

	// digit places, most significant first: weight, rounding threshold, byte, bit pairs
	localparam int WEIGHT [5] = '{81, 27, 9, 3, 1};
	localparam int THRESH [5] = '{41, 14, 5, 2, 1};
	localparam int BYTE_OF[5] = '{2, 1, 0, 1, 0};
	localparam int X_PLUS [5] = '{2, 2, 2, 0, 0};
	localparam int X_MINUS[5] = '{3, 3, 3, 1, 1};
	localparam int Y_PLUS [5] = '{5, 5, 5, 7, 7};
	localparam int Y_MINUS[5] = '{4, 4, 4, 6, 6};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 end_m;
		logic                 jump_m;
		logic                 trim_m;
		logic                 stop_m;
	} stitch_t;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       err;
	} record_t;

	typedef struct packed {
		stitch_t st;
		logic    fixed;
		record_t rec;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sbte_stitch_if #(.COORD_WIDTH(CW)) stitch_ch ();
	sbte_record_if                     rec_ch ();

	stitch_balanced_ternary_encoder #(.COORD_WIDTH(CW)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stitch (stitch_ch),
		.rec    (rec_ch)
	);

	always begin
		#HALF_CLK clk = 1'b1;
		#HALF_CLK clk = 1'b0;
	end

	logic signed [CW-1:0] prev_x;
	logic signed [CW-1:0] prev_y;
	record_t              records_due[$];
	plan_row_t            plan[$];
	int                   err_count;
	int                   stitches_sent;
	int                   records_seen;
	int                   clamp_count;
	int                   end_count;
	int                   cycles;
	bit                   quiet;
	bit                   hold_req;

	function automatic record_t predict_record(input stitch_t st);
		int         dx;
		int         dy;
		logic       clamped;
		logic [7:0] b [3];
		record_t    r;
		dx = int'(st.x) - int'(prev_x);
		dy = int'(st.y) - int'(prev_y);
		clamped = 1'b0;
		if (dx > DELTA_LIMIT) begin
			dx = DELTA_LIMIT;
			clamped = 1'b1;
		end else if (dx < -DELTA_LIMIT) begin
			dx = -DELTA_LIMIT;
			clamped = 1'b1;
		end
		if (dy > DELTA_LIMIT) begin
			dy = DELTA_LIMIT;
			clamped = 1'b1;
		end else if (dy < -DELTA_LIMIT) begin
			dy = -DELTA_LIMIT;
			clamped = 1'b1;
		end
		prev_x = st.x;
		prev_y = st.y;
		b[0] = 8'h00;
		b[1] = 8'h00;
		b[2] = 8'h00;
		for (int i = 0; i < 5; i++) begin
			if (dx >= THRESH[i]) begin
				b[BYTE_OF[i]][X_PLUS[i]] = 1'b1;
				dx -= WEIGHT[i];
			end else if (dx <= -THRESH[i]) begin
				b[BYTE_OF[i]][X_MINUS[i]] = 1'b1;
				dx += WEIGHT[i];
			end
			if (dy >= THRESH[i]) begin
				b[BYTE_OF[i]][Y_PLUS[i]] = 1'b1;
				dy -= WEIGHT[i];
			end else if (dy <= -THRESH[i]) begin
				b[BYTE_OF[i]][Y_MINUS[i]] = 1'b1;
				dy += WEIGHT[i];
			end
		end
		b[2] |= SYNC_BITS;
		if (st.end_m) begin
			b[0] = 8'h00;
			b[1] = 8'h00;
			b[2] = END_BYTE2;
		end
		if (st.jump_m || st.trim_m)
			b[2] |= JUMP_TRIM_BITS;
		if (st.stop_m)
			b[2] |= STOP_BITS;
		r.b0  = b[0];
		r.b1  = b[1];
		r.b2  = b[2];
		r.err = clamped;
		return r;
	endfunction

	function automatic int idle_gap();
		if (quiet)
			return 0;
		return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 9)) : 0;
	endfunction

	// mostly deltas within the clamp limit, some near it, some full-range positions
	function automatic stitch_t random_stitch();
		stitch_t st;
		int      dx;
		int      dy;
		int      mode;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			st.x = CW'($urandom());
			st.y = CW'($urandom());
		end else begin
			if (mode <= 2) begin
				dx = int'($urandom_range(0, 50)) - 25 + ($urandom_range(0, 1) ? 121 : -121);
				dy = int'($urandom_range(0, 50)) - 25 + ($urandom_range(0, 1) ? 121 : -121);
			end else begin
				dx = int'($urandom_range(0, 242)) - 121;
				dy = int'($urandom_range(0, 242)) - 121;
			end
			st.x = CW'(int'(prev_x) + dx);
			st.y = CW'(int'(prev_y) + dy);
		end
		st.end_m  = ($urandom_range(0, 15) == 0);
		st.jump_m = ($urandom_range(0, 7) == 0);
		st.trim_m = ($urandom_range(0, 7) == 0);
		st.stop_m = ($urandom_range(0, 9) == 0);
		return st;
	endfunction

	task automatic add_row(input int x, input int y, input bit e, input bit j, input bit t,
			input bit s, input bit fixed, input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input bit err);
		plan_row_t row;
		row.st.x      = CW'(x);
		row.st.y      = CW'(y);
		row.st.end_m  = e;
		row.st.jump_m = j;
		row.st.trim_m = t;
		row.st.stop_m = s;
		row.fixed     = fixed;
		row.rec.b0    = b0;
		row.rec.b1    = b1;
		row.rec.b2    = b2;
		row.rec.err   = err;
		plan.push_back(row);
	endtask

	// offer one stitch, hold it until the transfer, then queue its record
	task automatic offer_stitch(input stitch_t st, input int gap, input bit fixed,
			input record_t fixed_rec);
		record_t pred;
		if (gap > 0) begin
			stitch_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stitch_ch.pos_x     <= st.x;
		stitch_ch.pos_y     <= st.y;
		stitch_ch.end_mark  <= st.end_m;
		stitch_ch.jump_mark <= st.jump_m;
		stitch_ch.trim_mark <= st.trim_m;
		stitch_ch.stop_mark <= st.stop_m;
		stitch_ch.valid     <= 1'b1;
		do @(posedge clk); while (!stitch_ch.ready);
		pred = predict_record(st);
		records_due.push_back(fixed ? fixed_rec : pred);
		stitches_sent++;
		if (pred.err)
			clamp_count++;
		if (st.end_m)
			end_count++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("%0t timeout with %0d records outstanding", $time, records_due.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	// record checker
	always @(posedge clk) begin
		record_t got;
		record_t want;
		if (arst_n && rec_ch.valid && rec_ch.ready) begin
			got.b0  = rec_ch.out_byte0;
			got.b1  = rec_ch.out_byte1;
			got.b2  = rec_ch.out_byte2;
			got.err = rec_ch.range_error;
			records_seen++;
			if (records_due.size() == 0) begin
				err_count++;
				$display("%0t unexpected record %h %h %h err=%b", $time,
					got.b0, got.b1, got.b2, got.err);
			end else begin
				want = records_due.pop_front();
				if (got.b0 !== want.b0) begin
					err_count++;
					$display("%0t out_byte0 expected %h actual %h", $time, want.b0, got.b0);
				end
				if (got.b1 !== want.b1) begin
					err_count++;
					$display("%0t out_byte1 expected %h actual %h", $time, want.b1, got.b1);
				end
				if (got.b2 !== want.b2) begin
					err_count++;
					$display("%0t out_byte2 expected %h actual %h", $time, want.b2, got.b2);
				end
				if (got.err !== want.err) begin
					err_count++;
					$display("%0t range_error expected %b actual %b", $time, want.err, got.err);
				end
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request, none at the end
	initial begin
		rec_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				rec_ch.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rec_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				rec_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		record_t none;
		none                = '0;
		arst_n              = 1'b0;
		stitch_ch.valid     = 1'b0;
		stitch_ch.pos_x     = '0;
		stitch_ch.pos_y     = '0;
		stitch_ch.end_mark  = 1'b0;
		stitch_ch.jump_mark = 1'b0;
		stitch_ch.trim_mark = 1'b0;
		stitch_ch.stop_mark = 1'b0;
		prev_x        = '0;
		prev_y        = '0;
		err_count     = 0;
		stitches_sent = 0;
		records_seen  = 0;
		clamp_count   = 0;
		end_count     = 0;
		cycles        = 0;
		quiet         = 1'b0;
		hold_req      = 1'b0;

		// x,y, end jump trim stop, fixed, bytes, range flag
		add_row(     0,      0, 0, 0, 0, 0, 1, 8'h00, 8'h00, 8'h03, 0);
		add_row(   121,      0, 0, 0, 0, 0, 1, 8'h05, 8'h05, 8'h07, 0);
		add_row(     0,      0, 0, 0, 0, 0, 1, 8'h0A, 8'h0A, 8'h0B, 0);
		add_row(     0,    121, 0, 0, 0, 0, 1, 8'hA0, 8'hA0, 8'h23, 0);
		add_row(     0,      0, 0, 0, 0, 0, 1, 8'h50, 8'h50, 8'h13, 0);
		add_row( 32767, -32768, 0, 0, 0, 0, 1, 8'h55, 8'h55, 8'h17, 1);
		add_row(-32768,  32767, 0, 0, 0, 0, 1, 8'hAA, 8'hAA, 8'h2B, 1);
		add_row(-32763,  32767, 1, 0, 0, 0, 1, 8'h00, 8'h00, 8'hF3, 0);
		add_row(-32763,  32767, 1, 1, 0, 1, 1, 8'h00, 8'h00, 8'hF3, 0);
		add_row(     0,      0, 1, 0, 1, 0, 1, 8'h00, 8'h00, 8'hF3, 1);
		add_row(     0,      0, 0, 1, 0, 0, 1, 8'h00, 8'h00, 8'h83, 0);
		add_row(     0,      0, 0, 0, 1, 0, 1, 8'h00, 8'h00, 8'h83, 0);
		add_row(     0,      0, 0, 0, 0, 1, 1, 8'h00, 8'h00, 8'hC3, 0);
		add_row(     0,      0, 0, 1, 1, 1, 1, 8'h00, 8'h00, 8'hC3, 0);
		add_row(   122,   -122, 0, 0, 0, 0, 1, 8'h55, 8'h55, 8'h17, 1);
		// digit rounding at each threshold, checked by the predictor
		add_row(   163,   -163, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
		add_row(   203,   -203, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
		add_row(   204,   -204, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
		add_row(   203,   -202, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
		add_row(   205,   -204, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
		add_row(   218,   -190, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
		add_row(   222,   -195, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
		add_row(   222,   -195, 0, 0, 0, 1, 0, 8'h00, 8'h00, 8'h00, 0);
		add_row(   101,    -74, 0, 1, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
		add_row(   -20,     48, 0, 0, 1, 0, 0, 8'h00, 8'h00, 8'h00, 0);

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			offer_stitch(plan[i].st, idle_gap(), plan[i].fixed, plan[i].rec);

		// drain, then stall the receiver while offering back to back
		stitch_ch.valid <= 1'b0;
		wait (records_due.size() == 0);
		@(posedge clk);
		hold_req = 1'b1;
		repeat (HOLD_ITEMS)
			offer_stitch(random_stitch(), 0, 1'b0, none);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == QUIET_FROM)
				quiet = 1'b1;
			offer_stitch(random_stitch(), idle_gap(), 1'b0, none);
		end
		stitch_ch.valid <= 1'b0;

		wait (records_due.size() == 0);
		repeat (TAIL_CYC) @(posedge clk);

		$display("summary: %0d stitches, %0d records checked, %0d clamped, %0d end records",
			stitches_sent, records_seen, clamp_count, end_count);
		$display("summary: marks, coordinate extremes, a long output stall and idle gaps run");
		if (err_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
